@@ rtl/lkd_pkg.sv @@
// Shared types, constants and the LFSR step function of the frame descrambler.
// No dependencies; the top level takes it in.

package lkd_pkg;

  // Frame layout
  localparam int FRAME_MAX_DEFAULT = 256;
  localparam int SEED_FIRST_POS    = 2;
  localparam int SEED_LAST_POS     = 13;
  localparam int CHECK_POS         = 14;
  localparam int PAYLOAD_POS       = 15;

  // Check constants
  localparam logic [7:0] HEADER_BYTE = 8'h4B;
  localparam logic [7:0] CHECK_MASK  = 8'hEF;

  // LFSR taps
  localparam logic [31:0] LFSR_TAPS = 32'h8000_0806;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCRAMBLE_KEY = 1'b0,
    REG_HEADER_MODE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_SHORT    = 2'd1,
    VERDICT_HEADER   = 2'd2,
    VERDICT_CHECKSUM = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] origin_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       has_byte;
    logic       is_final;
    logic [1:0] verdict;
    logic [7:0] payload_length;
  } result_item_t;

  // Advance the LFSR by eight bits; the new bit enters at bit 0.
  function automatic logic [31:0] lfsr_eight(input logic [31:0] r);
    logic [31:0] s;
    s = r;
    for (int k = 0; k < 8; k++) begin
      s = {s[30:0], ^(s & LFSR_TAPS)};
    end
    return s;
  endfunction

endpackage

@@ rtl/lkd_stream_if.sv @@
// Valid/ready channel that carries one request of the payload type given.
// Payload types come from lkd_pkg.

interface lkd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lfsr_keystream_frame_descrambler.sv @@
// Top level of the frame descrambler: seed build, LFSR keystream, checksum,
// verdict and a two-entry result buffer. Uses lkd_pkg and lkd_stream_if.
//
// Usage:
//   byte_ch carries one frame byte per request, with the original header byte
//   at the same index and a last-byte flag. result_ch carries the descrambled
//   bytes from index 15 on, and on the last byte the verdict and the payload
//   length. Header bytes that are not the last give no result.
//   Bytes go out before the verdict; drop the frame's bytes unless the final
//   result reports ok.
//   An accepted byte's result is registered before it goes out on result_ch.
//   Throughput is one byte per cycle while result_ch does not stall: the eight
//   LFSR shifts, the seed XOR and the checksum add are all combinational.
//   When result_ch stalls, one more result goes into a skid register, then
//   byte_ch.ready drops until the skid register drains.
//   The configuration port takes scramble_key (index 0) and header_check_mode
//   (index 1); the key is sampled at byte 14 and the mode at the last byte.
//   Synchronous reset clears the frame state, both registers and the buffer.

module lfsr_keystream_frame_descrambler #(
  parameter int FRAME_MAX = lkd_pkg::FRAME_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lkd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lkd_pkg::CFG_DATA_W-1:0]  cfg_data,
  lkd_stream_if.sink                     byte_ch,
  lkd_stream_if.source                   result_ch
);

  localparam int POS_W = $clog2(FRAME_MAX + 1);

  // Configuration registers
  logic [31:0] scramble_key;
  logic        header_check_mode;

  // Frame state
  logic [31:0]      lfsr_register, lfsr_register_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       expected_check, expected_check_next;
  logic             header_failed, header_failed_next;

  // Result buffer
  logic                  out_valid;
  lkd_pkg::result_item_t out_item;
  logic                  skid_valid;
  lkd_pkg::result_item_t skid_item;

  logic                  accept;
  logic                  produce;
  logic                  out_free;
  lkd_pkg::result_item_t result;
  lkd_pkg::byte_item_t   req;

  logic [1:0]  lane;
  logic [7:0]  seed_byte;
  logic [31:0] stepped;
  logic [7:0]  plain;
  logic        is_payload;

  assign req    = byte_ch.payload;
  assign accept = byte_ch.valid && byte_ch.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_key      <= '0;
      header_check_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (lkd_pkg::cfg_reg_e'(cfg_index))
        lkd_pkg::REG_SCRAMBLE_KEY: scramble_key      <= cfg_data[31:0];
        lkd_pkg::REG_HEADER_MODE:  header_check_mode <= cfg_data[0];
      endcase
    end
  end

  // Byte lane of the seed: index 2, 6 and 10 land in the top byte
  assign lane      = byte_position[1:0] + 2'd2;
  assign seed_byte = (byte_position >= POS_W'(10)) ? req.frame_byte : req.origin_byte;

  assign stepped    = lkd_pkg::lfsr_eight(lfsr_register);
  assign is_payload = byte_position >= POS_W'(lkd_pkg::PAYLOAD_POS);
  assign plain      = is_payload ? (req.frame_byte ^ stepped[7:0]) : 8'h00;

  // Next frame state and the result for this byte
  always_comb begin
    lfsr_register_next  = lfsr_register;
    running_sum_next    = running_sum;
    expected_check_next = expected_check;
    header_failed_next  = header_failed;
    byte_position_next  = byte_position;

    if (byte_position >= POS_W'(lkd_pkg::SEED_FIRST_POS) &&
        byte_position <= POS_W'(lkd_pkg::SEED_LAST_POS)) begin
      lfsr_register_next = lfsr_register ^ (32'(seed_byte) << {~lane, 3'b000});
    end else if (byte_position == POS_W'(lkd_pkg::CHECK_POS)) begin
      lfsr_register_next  = lfsr_register ^ scramble_key;
      expected_check_next = req.frame_byte & lkd_pkg::CHECK_MASK;
    end else if (is_payload) begin
      lfsr_register_next = stepped;
      running_sum_next   = running_sum + plain;
      if (byte_position == POS_W'(lkd_pkg::PAYLOAD_POS) && plain != lkd_pkg::HEADER_BYTE) begin
        header_failed_next = 1'b1;
      end
    end

    if (byte_position < POS_W'(FRAME_MAX)) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    result.plain_byte     = plain;
    result.has_byte       = is_payload;
    result.is_final       = req.frame_end;
    result.verdict        = lkd_pkg::VERDICT_OK;
    result.payload_length = 8'h00;
    if (req.frame_end) begin
      if (!is_payload) begin
        result.verdict = lkd_pkg::VERDICT_SHORT;
      end else begin
        // Position never exceeds FRAME_MAX, so the length stays below 256 while FRAME_MAX is under 270
        result.payload_length = 8'(byte_position - POS_W'(lkd_pkg::CHECK_POS));
        if (header_check_mode) begin
          if (header_failed_next) result.verdict = lkd_pkg::VERDICT_HEADER;
        end else if ((running_sum_next & lkd_pkg::CHECK_MASK) != expected_check) begin
          result.verdict = lkd_pkg::VERDICT_CHECKSUM;
        end
      end
    end
  end

  assign produce = accept && (is_payload || req.frame_end);

  // Advance frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_register  <= '0;
      byte_position  <= '0;
      running_sum    <= '0;
      expected_check <= '0;
      header_failed  <= 1'b0;
    end else if (accept) begin
      if (req.frame_end) begin
        lfsr_register  <= '0;
        byte_position  <= '0;
        running_sum    <= '0;
        expected_check <= '0;
        header_failed  <= 1'b0;
      end else begin
        lfsr_register  <= lfsr_register_next;
        byte_position  <= byte_position_next;
        running_sum    <= running_sum_next;
        expected_check <= expected_check_next;
        header_failed  <= header_failed_next;
      end
    end
  end

  // Output register with a skid stage behind it
  assign out_free      = !out_valid || result_ch.ready;
  assign byte_ch.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item <= skid_valid ? skid_item : result;
    end else if (produce) begin
      skid_item <= result;
    end
  end

  assign result_ch.valid   = out_valid;
  assign result_ch.payload = out_item;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.has_byte) |-> out_item.is_final)
    else $error("result without byte that is not final");

  a_verdict_on_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.is_final) |->
      (out_item.verdict == lkd_pkg::VERDICT_OK && out_item.payload_length == 8'h00))
    else $error("verdict or length on a non-final result");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && req.frame_end) |=> (byte_position == '0 && lfsr_register == '0))
    else $error("frame state not cleared after last byte");

endmodule
